>>> rtl/hightenc_pkg.sv
// HIGHT-64/128 encryption package: block and key types, the delta table,
// the byte functions F0/F1 and the subkey derivation.
// No dependencies; used by hightenc_round and hight_block_encrypt.
package hightenc_pkg;

	localparam int MAX_ROUNDS = 32;
	localparam int ROUND_W    = 6;
	localparam int RIDX_W     = 5;
	localparam int BLOCK_W    = 64;
	localparam int KEY_W      = 128;

	typedef logic [7:0][7:0]  block_t;
	typedef logic [15:0][7:0] key_t;
	typedef logic [RIDX_W-1:0]  ridx_t;
	typedef logic [ROUND_W-1:0] rcount_t;

	localparam logic [7:0] DELTA [128] = '{
		8'h5A,8'h6D,8'h36,8'h1B,8'h0D,8'h06,8'h03,8'h41,
		8'h60,8'h30,8'h18,8'h4C,8'h66,8'h33,8'h59,8'h2C,
		8'h56,8'h2B,8'h15,8'h4A,8'h65,8'h72,8'h39,8'h1C,
		8'h4E,8'h67,8'h73,8'h79,8'h3C,8'h5E,8'h6F,8'h37,
		8'h5B,8'h2D,8'h16,8'h0B,8'h05,8'h42,8'h21,8'h50,
		8'h28,8'h54,8'h2A,8'h55,8'h6A,8'h75,8'h7A,8'h7D,
		8'h3E,8'h5F,8'h2F,8'h17,8'h4B,8'h25,8'h52,8'h29,
		8'h14,8'h0A,8'h45,8'h62,8'h31,8'h58,8'h6C,8'h76,
		8'h3B,8'h1D,8'h0E,8'h47,8'h63,8'h71,8'h78,8'h7C,
		8'h7E,8'h7F,8'h3F,8'h1F,8'h0F,8'h07,8'h43,8'h61,
		8'h70,8'h38,8'h5C,8'h6E,8'h77,8'h7B,8'h3D,8'h1E,
		8'h4F,8'h27,8'h53,8'h69,8'h34,8'h1A,8'h4D,8'h26,
		8'h13,8'h49,8'h24,8'h12,8'h09,8'h04,8'h02,8'h01,
		8'h40,8'h20,8'h10,8'h08,8'h44,8'h22,8'h11,8'h48,
		8'h64,8'h32,8'h19,8'h0C,8'h46,8'h23,8'h51,8'h68,
		8'h74,8'h3A,8'h5D,8'h2E,8'h57,8'h6B,8'h35,8'h5A
	};

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int unsigned n);
		rotl8 = (x << n) | (x >> (8 - n));
	endfunction

	function automatic logic [7:0] hf0(input logic [7:0] x);
		hf0 = rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 7);
	endfunction

	function automatic logic [7:0] hf1(input logic [7:0] x);
		hf1 = rotl8(x, 3) ^ rotl8(x, 4) ^ rotl8(x, 6);
	endfunction

	// subkey idx = 16*blk + j; master byte rotates by blk within each key half
	function automatic logic [7:0] subkey(input key_t key, input logic [6:0] idx);
		logic [2:0] blk;
		logic [3:0] j;
		logic [2:0] m;
		blk = idx[6:4];
		j   = idx[3:0];
		m   = j[2:0] - blk;
		subkey = key[{j[3], m}] + DELTA[idx];
	endfunction

endpackage

>>> rtl/hightenc_round.sv
// One HIGHT round as a pipeline stage with its own valid bit and key copy.
// Depends on hightenc_pkg; instantiated 32 times by hight_block_encrypt.
module hightenc_round (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  hightenc_pkg::ridx_t  round_idx,
	input  hightenc_pkg::rcount_t rounds,
	input  logic                 valid_in,
	input  hightenc_pkg::block_t x_in,
	input  hightenc_pkg::key_t   key_in,
	output logic                 valid_s1,
	output hightenc_pkg::block_t x_s1,
	output hightenc_pkg::key_t   key_s1
);
	import hightenc_pkg::*;

	logic [3:0][7:0] k;
	block_t t;
	logic   active;

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			k[n] = subkey(key_in, {round_idx, 2'(n)});
		end
		active = {1'b0, round_idx} < rounds;
		t[0] = x_in[7] ^ (hf0(x_in[6]) + k[3]);
		t[1] = x_in[0];
		t[2] = x_in[1] + (hf1(x_in[0]) ^ k[0]);
		t[3] = x_in[2];
		t[4] = x_in[3] ^ (hf0(x_in[2]) + k[1]);
		t[5] = x_in[4];
		t[6] = x_in[5] + (hf1(x_in[4]) ^ k[2]);
		t[7] = x_in[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	// pass the state through unchanged beyond the configured round count
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= active ? t : x_in;
			key_s1 <= key_in;
		end
	end

endmodule

>>> rtl/hight_block_encrypt.sv
// HIGHT-64/128 block encryption top level: input whitening stage, 32 round
// stages, final whitening into an output register with a one-entry skid.
// Depends on hightenc_pkg and hightenc_round.

// Accepts one plaintext/key request per cycle while the skid entry is empty
// (s_axis_tready is low otherwise) and returns one ciphertext per request in order.
// A request goes through the whitening stage, which loads at the accepting edge,
// then one register per round for all 32 rounds (rounds beyond round_count pass
// the state through), then the output register. round_count is written through
// cfg_we/cfg_wdata; the user must do so only while no request is in flight, and
// the block itself does not enforce it. 0 acts as 1 and values above 32 act as 32.
module hight_block_encrypt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [5:0]   cfg_wdata,      // round_count
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,   // plain_block, key_low, key_high
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata    // cipher_block
);
	import hightenc_pkg::*;

	rcount_t round_count_q;
	rcount_t rounds_eff;
	logic    en;
	logic    take;

	logic   valid_s0;
	block_t x_s0;
	key_t   key_s0;

	logic   v_chain   [MAX_ROUNDS+1];
	block_t x_chain   [MAX_ROUNDS+1];
	key_t   key_chain [MAX_ROUNDS+1];

	block_t p;
	key_t   mk;
	block_t xw;
	block_t fin_d;
	block_t xf;
	key_t   kf;

	logic   out_v_q;
	block_t out_d_q;
	logic   skid_v_q;
	block_t skid_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q <= ROUND_W'(MAX_ROUNDS);
		end else if (cfg_we) begin
			round_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (round_count_q == '0) begin
			rounds_eff = ROUND_W'(1);
		end else if (round_count_q > ROUND_W'(MAX_ROUNDS)) begin
			rounds_eff = ROUND_W'(MAX_ROUNDS);
		end else begin
			rounds_eff = round_count_q;
		end
	end

	assign en            = !skid_v_q;
	assign s_axis_tready = en;
	assign take          = out_v_q && m_axis_tready;

	// initial whitening
	always_comb begin
		p  = s_axis_tdata[63:0];
		mk = s_axis_tdata[191:64];
		xw    = p;
		xw[0] = p[0] + mk[12];
		xw[2] = p[2] ^ mk[13];
		xw[4] = p[4] + mk[14];
		xw[6] = p[6] ^ mk[15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s0   <= xw;
			key_s0 <= mk;
		end
	end

	assign v_chain[0]   = valid_s0;
	assign x_chain[0]   = x_s0;
	assign key_chain[0] = key_s0;

	for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_round
		hightenc_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.round_idx (RIDX_W'(r)),
			.rounds    (rounds_eff),
			.valid_in  (v_chain[r]),
			.x_in      (x_chain[r]),
			.key_in    (key_chain[r]),
			.valid_s1  (v_chain[r+1]),
			.x_s1      (x_chain[r+1]),
			.key_s1    (key_chain[r+1])
		);
	end

	// final whitening; byte mapping undoes the last rotation
	always_comb begin
		xf = x_chain[MAX_ROUNDS];
		kf = key_chain[MAX_ROUNDS];
		fin_d[0] = xf[1] + kf[0];
		fin_d[1] = xf[2];
		fin_d[2] = xf[3] ^ kf[1];
		fin_d[3] = xf[4];
		fin_d[4] = xf[5] + kf[2];
		fin_d[5] = xf[6];
		fin_d[6] = xf[7] ^ kf[3];
		fin_d[7] = xf[0];
	end

	// output register plus skid entry; pipeline holds while the skid is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= v_chain[MAX_ROUNDS];
		end else if (v_chain[MAX_ROUNDS]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_d_q <= skid_d_q;
			end
		end else if (!out_v_q || take) begin
			out_d_q <= fin_d;
		end else begin
			skid_d_q <= fin_d;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_d_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without a pending output");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready && v_chain[MAX_ROUNDS]))
		else $error("skid filled without an output stall");

	a_stage0_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> valid_s0 == $past(s_axis_tvalid))
		else $error("stage 0 valid does not follow the request");

	a_hold_on_skid: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> v_chain[MAX_ROUNDS] == $past(v_chain[MAX_ROUNDS]))
		else $error("last round stage moved while the skid was full");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for hight_block_encrypt: directed vectors, then random
// plaintext/key requests over several round settings, checked against typed or
// in-bench predicted ciphertexts. Depends on hightenc_pkg and hight_block_encrypt.
module testbench;
	import hightenc_pkg::rcount_t;
	import hightenc_pkg::MAX_ROUNDS;

	localparam int NUM_VECTORS  = 20;
	localparam int PHASES       = 8;
	localparam int PHASE_BLOCKS = 125;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 40;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		rcount_t     rounds;
		logic [63:0] plain;
		logic [63:0] key_lo;
		logic [63:0] key_hi;
		logic        known;
		logic [63:0] cipher;
	} vector_t;

	// rounds, plaintext, key bytes 0..7, key bytes 8..15, typed?, ciphertext
	vector_t vectors [NUM_VECTORS] = '{
		'{6'd32, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0},
		'{6'd32, ONES, ONES, ONES, 1'b0, 64'h0},
		'{6'd32, ONES, 64'h0, 64'h0, 1'b0, 64'h0},
		'{6'd32, 64'h0, ONES, ONES, 1'b0, 64'h0},
		'{6'd32, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555, 1'b0, 64'h0},
		'{6'd32, 64'h0, 64'h8899_AABB_CCDD_EEFF, 64'h0011_2233_4455_6677, 1'b0, 64'h0},
		'{6'd32, 64'h8000_0000_0000_0001, 64'h0000_0000_0000_0080,
			64'h8000_0000_0000_0000, 1'b0, 64'h0},
		'{6'd32, 64'h0123_4567_89AB_CDEF, 64'h0F1E_2D3C_4B5A_6978,
			64'hF0E1_D2C3_B4A5_9687, 1'b0, 64'h0},
		'{6'd1, 64'h0, 64'h0, 64'h0, 1'b1, 64'h1B00_3600_6D00_5A00},
		'{6'd1, 64'h0, ONES, ONES, 1'b1, 64'h1900_CAFE_6B00_A6FE},
		'{6'd1, ONES, ONES, ONES, 1'b0, 64'h0},
		'{6'd0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h1B00_3600_6D00_5A00},
		'{6'd0, 64'hDEAD_BEEF_0BAD_F00D, 64'h1357_9BDF_2468_ACE0,
			64'hFEDC_BA98_7654_3210, 1'b0, 64'h0},
		'{6'd63, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0},
		'{6'd63, ONES, ONES, ONES, 1'b0, 64'h0},
		'{6'd33, 64'h0123_4567_89AB_CDEF, 64'h0F1E_2D3C_4B5A_6978,
			64'hF0E1_D2C3_B4A5_9687, 1'b0, 64'h0},
		'{6'd2, 64'h0123_4567_89AB_CDEF, 64'h0F1E_2D3C_4B5A_6978,
			64'hF0E1_D2C3_B4A5_9687, 1'b0, 64'h0},
		'{6'd31, 64'h0123_4567_89AB_CDEF, 64'h0F1E_2D3C_4B5A_6978,
			64'hF0E1_D2C3_B4A5_9687, 1'b0, 64'h0},
		'{6'd16, ONES, 64'h0, ONES, 1'b0, 64'h0},
		'{6'd32, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0}
	};

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [5:0]   cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;   // plain_block, key_low, key_high
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;   // cipher_block

	logic [7:0]  delta_seq [128];
	logic [63:0] cipher_expect_q [$];
	rcount_t     rounds_cfg;
	bit          steady;
	int          mismatches;
	int          blocks_sent;
	int          ciphers_seen;
	int          settings_used;
	int          cycles = 0;

	hight_block_encrypt dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("hight_block_encrypt regression: fail");
			$finish;
		end
	end

	function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
		logic [15:0] w;
		w = {x, x} << n;
		return w[15:8];
	endfunction

	function automatic logic [7:0] mix_even(input logic [7:0] x);
		return rol8(x, 1) ^ rol8(x, 2) ^ rol8(x, 7);
	endfunction

	function automatic logic [7:0] mix_odd(input logic [7:0] x);
		return rol8(x, 3) ^ rol8(x, 4) ^ rol8(x, 6);
	endfunction

	function automatic logic [63:0] hight_cipher(input logic [63:0] pt, input logic [127:0] key,
			input rcount_t rc);
		logic [7:0] mk [16];
		logic [7:0] wk [8];
		logic [7:0] x [8];
		logic [7:0] nx [8];
		logic [7:0] rk [4];
		logic [7:0] ct [8];
		logic [63:0] res;
		int rounds;
		int idx;
		int half;
		int m;
		for (int i = 0; i < 16; i++)
			mk[i] = key[8*i +: 8];
		for (int i = 0; i < 4; i++) begin
			wk[i] = mk[i + 12];
			wk[i + 4] = mk[i];
		end
		rounds = (rc == 0) ? 1 : (rc > MAX_ROUNDS) ? MAX_ROUNDS : int'(rc);
		for (int i = 0; i < 8; i++)
			x[i] = pt[8*i +: 8];
		x[0] = x[0] + wk[0];
		x[2] = x[2] ^ wk[1];
		x[4] = x[4] + wk[2];
		x[6] = x[6] ^ wk[3];
		for (int r = 0; r < rounds; r++) begin
			for (int j = 0; j < 4; j++) begin
				idx = 4 * r + j;
				half = (idx % 16 >= 8) ? 8 : 0;
				m = ((idx % 8) + 8 - idx / 16) % 8;
				rk[j] = mk[m + half] + delta_seq[idx];
			end
			nx[0] = x[7] ^ (mix_even(x[6]) + rk[3]);
			nx[1] = x[0];
			nx[2] = x[1] + (mix_odd(x[0]) ^ rk[0]);
			nx[3] = x[2];
			nx[4] = x[3] ^ (mix_even(x[2]) + rk[1]);
			nx[5] = x[4];
			nx[6] = x[5] + (mix_odd(x[4]) ^ rk[2]);
			nx[7] = x[6];
			x = nx;
		end
		ct[0] = x[1] + wk[4];
		ct[1] = x[2];
		ct[2] = x[3] ^ wk[5];
		ct[3] = x[4];
		ct[4] = x[5] + wk[6];
		ct[5] = x[6];
		ct[6] = x[7] ^ wk[7];
		ct[7] = x[0];
		for (int i = 0; i < 8; i++)
			res[8*i +: 8] = ct[i];
		return res;
	endfunction

	// enter and leave at a falling edge
	task automatic send_block(input logic [63:0] pt, input logic [63:0] klo,
			input logic [63:0] khi, input logic known, input logic [63:0] typed_ct);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {khi, klo, pt};
		do @(posedge clk); while (!s_axis_tready);
		cipher_expect_q.push_back(known ? typed_ct : hight_cipher(pt, {khi, klo}, rounds_cfg));
		blocks_sent++;
		@(negedge clk);
	endtask

	// drain, then write round_count while idle
	task automatic set_rounds(input rcount_t value);
		s_axis_tvalid <= 1'b0;
		while (cipher_expect_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		rounds_cfg = value;
		settings_used++;
	endtask

	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 7))
			0: return 64'h0;
			1: return ONES;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = steady ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			ciphers_seen++;
			if (cipher_expect_q.size() == 0) begin
				$error("cipher_block unexpected: expected none, got %h", m_axis_tdata);
				mismatches++;
			end else begin
				logic [63:0] want;
				want = cipher_expect_q.pop_front();
				if (m_axis_tdata !== want) begin
					$error("cipher_block mismatch: expected %h, got %h", want, m_axis_tdata);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [6:0] lfsr;
		rcount_t phase_rounds [PHASES];
		mismatches = 0;
		blocks_sent = 0;
		ciphers_seen = 0;
		settings_used = 1;
		steady = 1'b0;
		rounds_cfg = rcount_t'(MAX_ROUNDS);
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;

		lfsr = 7'h5A;
		for (int i = 0; i < 128; i++) begin
			delta_seq[i] = {1'b0, lfsr};
			lfsr = {lfsr[3] ^ lfsr[0], lfsr[6:1]};
		end

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int v = 0; v < NUM_VECTORS; v++) begin
			if (vectors[v].rounds != rounds_cfg || v == NUM_VECTORS - 1)
				set_rounds(vectors[v].rounds);
			send_block(vectors[v].plain, vectors[v].key_lo, vectors[v].key_hi,
				vectors[v].known, vectors[v].cipher);
		end

		phase_rounds = '{6'd32, 6'd1, 6'd0, 6'd63, rcount_t'($urandom_range(1, 32)),
			rcount_t'($urandom_range(0, 63)), 6'd17, 6'd32};
		for (int p = 0; p < PHASES; p++) begin
			set_rounds(phase_rounds[p]);
			for (int n = 0; n < PHASE_BLOCKS; n++) begin
				if (n % 25 == 0)
					steady = ($urandom_range(0, 3) == 0);
				send_block(random_word(), random_word(), random_word(), 1'b0, 64'h0);
			end
			steady = 1'b0;
		end

		s_axis_tvalid <= 1'b0;
		while (cipher_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d plaintext/key requests (%0d directed) under %0d round settings",
			blocks_sent, NUM_VECTORS, settings_used);
		$display("checked %0d ciphertexts, %0d mismatches", ciphers_seen, mismatches);
		if (mismatches == 0)
			$display("hight_block_encrypt regression: pass");
		else
			$display("hight_block_encrypt regression: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/hightenc_pkg.sv
rtl/hightenc_round.sv
rtl/hight_block_encrypt.sv
tb/testbench.sv
